// ===== sv/crc16_frame_deframer_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the frame deframer.
// ----------------------------------------------------------------------------
`ifndef CRC16_FRAME_DEFRAMER_DEFINES_SVH
`define CRC16_FRAME_DEFRAMER_DEFINES_SVH

// Checked on every rising clock edge outside reset.
`define CRCDF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked on every rising clock edge, reset included.
`define CRCDF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

// ===== sv/crcdf_pkg.sv =====
// ----------------------------------------------------------------------------
// crcdf_pkg
// Shared constants, state encoding and interface structs of the deframer.
// ----------------------------------------------------------------------------
package crcdf_pkg;

  // Store geometry and frame limits.
  localparam int STORE_DEPTH = 64;
  localparam int MAX_PAYLOAD = 58;
  localparam int AW          = $clog2(STORE_DEPTH);
  localparam int FILL_W      = AW + 1;
  localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);
  localparam int TRAILER_LEN = 3;

  // Frame marker bytes.
  localparam logic [7:0] START_SHORT = 8'd2;
  localparam logic [7:0] START_LONG  = 8'd3;
  localparam logic [7:0] END_MARK    = 8'd3;

  // Header lengths for the two start bytes.
  localparam logic [1:0] HDR_SHORT = 2'd2;
  localparam logic [1:0] HDR_LONG  = 2'd3;

  // CRC-16/XMODEM generator polynomial.
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_HDR_A,
    ST_HDR_B,
    ST_LEN_A,
    ST_LEN_B,
    ST_LEN2_A,
    ST_LEN2_B,
    ST_CHK,
    ST_CRC_A,
    ST_CRC_B,
    ST_CRC_SH,
    ST_TRL_A,
    ST_TRL_B,
    ST_TRL_C,
    ST_TRL_D,
    ST_TRL_E,
    ST_TRL_F,
    ST_EMIT_A,
    ST_EMIT_B
  } state_e;

  // Frame store access.
  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    logic [AW-1:0] raddr;
  } mem_req_t;

  // Control of the bit-serial CRC unit.
  typedef struct packed {
    logic       clear;
    logic       load;
    logic       step;
    logic [7:0] data;
  } crc_ctl_t;

  // Load request towards the output register.
  typedef struct packed {
    logic       load;
    logic [7:0] data;
    logic       last;
  } out_req_t;

endpackage

// ===== sv/crcdf_store.sv =====
// ----------------------------------------------------------------------------
// crcdf_store
// Circular frame store: one write port and one registered read port.
// ----------------------------------------------------------------------------
module crcdf_store import crcdf_pkg::*; (
  input  logic     clk_i,
  input  mem_req_t mem_req_i,
  output logic [7:0] rdata_o
);

  logic [7:0] mem_q [STORE_DEPTH];
  logic [7:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (mem_req_i.we) begin
      mem_q[mem_req_i.waddr] <= mem_req_i.wdata;
    end
  end

  // Registered read port, sampled every cycle.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[mem_req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/crcdf_crc_unit.sv =====
// ----------------------------------------------------------------------------
// crcdf_crc_unit
// Bit-serial CRC-16/XMODEM register: one polynomial step per cycle while step is set.
// ----------------------------------------------------------------------------
module crcdf_crc_unit import crcdf_pkg::*; (
  input  logic        clk_i,
  input  crc_ctl_t    crc_ctl_i,
  output logic [15:0] crc_o
);

  logic [15:0] crc_q;
  logic [15:0] crc_d;

  // Clear, fold in a byte, or shift one bit through the generator.
  always_comb begin
    crc_d = crc_q;
    if (crc_ctl_i.clear) begin
      crc_d = '0;
    end else if (crc_ctl_i.load) begin
      crc_d = crc_q ^ {crc_ctl_i.data, 8'h00};
    end else if (crc_ctl_i.step) begin
      crc_d = {crc_q[14:0], 1'b0} ^ (crc_q[15] ? CRC_POLY : 16'h0000);
    end
  end

  always_ff @(posedge clk_i) begin
    crc_q <= crc_d;
  end

  assign crc_o = crc_q;

endmodule

// ===== sv/crcdf_ctrl.sv =====
// ----------------------------------------------------------------------------
// crcdf_ctrl
// Parse sequencer: appends each byte that fits, then walks the store header,
// CRC, trailer and payload one byte at a time, dropping bytes on faults.
// ----------------------------------------------------------------------------
module crcdf_ctrl import crcdf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic [7:0]  rx_byte_i,
  output logic        in_stall_o,
  input  logic [7:0]  rdata_i,
  input  logic [15:0] crc_i,
  input  logic        out_ready_i,
  output mem_req_t    mem_req_o,
  output crc_ctl_t    crc_ctl_o,
  output out_req_t    out_req_o
);

  state_e             state_q, state_d;
  logic [AW-1:0]      base_q, base_d;
  logic [FILL_W-1:0]  fill_q, fill_d;
  logic [AW-1:0]      off_q, off_d;
  logic [1:0]         hdr_q, hdr_d;
  logic [15:0]        len_q, len_d;
  logic [FILL_W-1:0]  total_q, total_d;
  logic [LEN_W-1:0]   idx_q, idx_d;
  logic [2:0]         bit_q, bit_d;
  logic [7:0]         crc_hi_q, crc_hi_d;
  logic               crc_ok_q, crc_ok_d;

  logic [16:0]        total_w;
  logic               len_bad;
  logic               byte_last;
  logic               frame_ok;

  // Frame geometry checks.
  assign total_w   = 17'(hdr_q) + 17'(len_q) + 17'(TRAILER_LEN);
  assign len_bad   = (len_q == 16'd0) || (len_q > 16'(MAX_PAYLOAD)) ||
                     (total_w > 17'(STORE_DEPTH));
  assign byte_last = (idx_q + LEN_W'(1)) == len_q[LEN_W-1:0];
  assign frame_ok  = (rdata_i == END_MARK) && crc_ok_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_HDR_A;
      ST_HDR_A:  state_d = (fill_q < FILL_W'(2)) ? ST_IDLE : ST_HDR_B;
      ST_HDR_B: begin
        if (rdata_i == START_SHORT) begin
          state_d = ST_LEN_A;
        end else if (rdata_i == START_LONG) begin
          state_d = (fill_q < FILL_W'(3)) ? ST_IDLE : ST_LEN_A;
        end else begin
          state_d = ST_HDR_A;
        end
      end
      ST_LEN_A:  state_d = ST_LEN_B;
      ST_LEN_B:  state_d = (hdr_q == HDR_SHORT) ? ST_CHK : ST_LEN2_A;
      ST_LEN2_A: state_d = ST_LEN2_B;
      ST_LEN2_B: state_d = ST_CHK;
      ST_CHK: begin
        if (len_bad) begin
          state_d = ST_HDR_A;
        end else if (fill_q < total_w[FILL_W-1:0]) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_CRC_A;
        end
      end
      ST_CRC_A:  state_d = ST_CRC_B;
      ST_CRC_B:  state_d = ST_CRC_SH;
      ST_CRC_SH: begin
        if (bit_q == 3'd7) begin
          state_d = byte_last ? ST_TRL_A : ST_CRC_A;
        end
      end
      ST_TRL_A:  state_d = ST_TRL_B;
      ST_TRL_B:  state_d = ST_TRL_C;
      ST_TRL_C:  state_d = ST_TRL_D;
      ST_TRL_D:  state_d = ST_TRL_E;
      ST_TRL_E:  state_d = ST_TRL_F;
      ST_TRL_F:  state_d = frame_ok ? ST_EMIT_A : ST_HDR_A;
      ST_EMIT_A: state_d = ST_EMIT_B;
      ST_EMIT_B: begin
        if (out_ready_i) begin
          state_d = byte_last ? ST_HDR_A : ST_EMIT_A;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // Datapath updates and outputs per state.
  always_comb begin
    base_d    = base_q;
    fill_d    = fill_q;
    off_d     = off_q;
    hdr_d     = hdr_q;
    len_d     = len_q;
    total_d   = total_q;
    idx_d     = idx_q;
    bit_d     = bit_q;
    crc_hi_d  = crc_hi_q;
    crc_ok_d  = crc_ok_q;
    in_stall_o = (state_q != ST_IDLE);
    mem_req_o = '0;
    mem_req_o.raddr = base_q + off_q;
    crc_ctl_o = '0;
    out_req_o = '0;
    case (state_q)
      ST_IDLE: begin
        off_d = '0;
        // A byte arriving at a full store is ignored.
        if (in_valid_i && (fill_q < FILL_W'(STORE_DEPTH))) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = base_q + fill_q[AW-1:0];
          mem_req_o.wdata = rx_byte_i;
          fill_d          = fill_q + FILL_W'(1);
        end
      end
      ST_HDR_B: begin
        if (rdata_i == START_SHORT) begin
          hdr_d = HDR_SHORT;
          off_d = AW'(1);
        end else if (rdata_i == START_LONG) begin
          hdr_d = HDR_LONG;
          off_d = AW'(1);
        end else begin
          base_d = base_q + AW'(1);
          fill_d = fill_q - FILL_W'(1);
          off_d  = '0;
        end
      end
      ST_LEN_B: begin
        if (hdr_q == HDR_SHORT) begin
          len_d = {8'h00, rdata_i};
        end else begin
          len_d = {rdata_i, 8'h00};
          off_d = AW'(2);
        end
      end
      ST_LEN2_B: len_d = {len_q[15:8], rdata_i};
      ST_CHK: begin
        if (len_bad) begin
          base_d = base_q + AW'(1);
          fill_d = fill_q - FILL_W'(1);
          off_d  = '0;
        end else begin
          total_d         = total_w[FILL_W-1:0];
          crc_ctl_o.clear = 1'b1;
          idx_d           = '0;
          off_d           = AW'(hdr_q);
        end
      end
      ST_CRC_B: begin
        crc_ctl_o.load = 1'b1;
        crc_ctl_o.data = rdata_i;
        bit_d          = '0;
      end
      ST_CRC_SH: begin
        crc_ctl_o.step = 1'b1;
        bit_d          = bit_q + 3'd1;
        if (bit_q == 3'd7) begin
          if (byte_last) begin
            off_d = AW'(hdr_q) + len_q[AW-1:0];
          end else begin
            idx_d = idx_q + LEN_W'(1);
            off_d = off_q + AW'(1);
          end
        end
      end
      ST_TRL_B: begin
        crc_hi_d = rdata_i;
        off_d    = off_q + AW'(1);
      end
      ST_TRL_D: begin
        crc_ok_d = (crc_i == {crc_hi_q, rdata_i});
        off_d    = off_q + AW'(1);
      end
      ST_TRL_F: begin
        if (frame_ok) begin
          off_d = AW'(hdr_q);
          idx_d = '0;
        end else begin
          base_d = base_q + AW'(1);
          fill_d = fill_q - FILL_W'(1);
          off_d  = '0;
        end
      end
      ST_EMIT_B: begin
        if (out_ready_i) begin
          out_req_o.load = 1'b1;
          out_req_o.data = rdata_i;
          out_req_o.last = byte_last;
          if (byte_last) begin
            // Whole frame consumed: release it from the store.
            base_d = base_q + total_q[AW-1:0];
            fill_d = fill_q - total_q;
            off_d  = '0;
          end else begin
            idx_d = idx_q + LEN_W'(1);
            off_d = off_q + AW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      base_q  <= '0;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      base_q  <= base_d;
      fill_q  <= fill_d;
    end
  end

  // Working registers of the current parse.
  always_ff @(posedge clk_i) begin
    off_q    <= off_d;
    hdr_q    <= hdr_d;
    len_q    <= len_d;
    total_q  <= total_d;
    idx_q    <= idx_d;
    bit_q    <= bit_d;
    crc_hi_q <= crc_hi_d;
    crc_ok_q <= crc_ok_d;
  end

endmodule

// ===== sv/crc16_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// crc16_frame_deframer
// Length-prefixed frame deframer with CRC-16/XMODEM check.
// ----------------------------------------------------------------------------
// Usage: one received byte is offered on rx_byte_i with in_valid_i. The
// request is taken when in_stall_o is low; the block then raises in_stall_o
// while it parses its 64-byte circular store, and lowers it when it needs
// more bytes. A byte that only leaves an incomplete frame, with no fault,
// keeps the block busy only while it reads back the held header and length.
// A candidate frame is checked by reading its payload back from the store,
// each byte being folded into the CRC and shifted one bit per cycle through
// a single unit, and every store read being registered. Each payload byte
// of a valid frame is then read and handed out before the next one is read.
// A fault makes the block drop the oldest held byte and rescan the rest.
// Payload bytes leave through an output register on out_valid_o,
// payload_byte_o and frame_end_o (high on the last byte of a frame); while
// out_stall_i is high that register holds and the sequencer waits before
// handing out the next byte. Reset clears the store pointers and the fill
// count, empties the output register and leaves the block ready for the
// first byte; no clearing pass is needed.
// ----------------------------------------------------------------------------
module crc16_frame_deframer import crcdf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] payload_byte_o,
  output logic       frame_end_o
);

  mem_req_t    mem_req;
  crc_ctl_t    crc_ctl;
  out_req_t    out_req;
  logic [7:0]  rdata;
  logic [15:0] crc;
  logic        out_ready;

  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_byte_q;
  logic        out_end_q;

  crcdf_store u_store (
    .clk_i     (clk_i),
    .mem_req_i (mem_req),
    .rdata_o   (rdata)
  );

  crcdf_crc_unit u_crc (
    .clk_i     (clk_i),
    .crc_ctl_i (crc_ctl),
    .crc_o     (crc)
  );

  crcdf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .rx_byte_i   (rx_byte_i),
    .in_stall_o  (in_stall_o),
    .rdata_i     (rdata),
    .crc_i       (crc),
    .out_ready_i (out_ready),
    .mem_req_o   (mem_req),
    .crc_ctl_o   (crc_ctl),
    .out_req_o   (out_req)
  );

  // The output register can take a byte when empty or being emptied.
  assign out_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_req.load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Output request valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (out_req.load) begin
      out_byte_q <= out_req.data;
      out_end_q  <= out_req.last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign payload_byte_o = out_byte_q;
  assign frame_end_o    = out_end_q;

endmodule

// ===== sv/crcdf_checker.sv =====
// ----------------------------------------------------------------------------
// crcdf_checker
// Port-level checks of the deframer, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "crc16_frame_deframer_defines.svh"

module crcdf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [7:0] rx_byte_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] payload_byte_o,
  input logic       frame_end_o
);

  // A stalled output request keeps its valid and payload.
  `CRCDF_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(payload_byte_o) && $stable(frame_end_o), "stalled output request changed")

  // Every accepted byte is parsed, so the block is busy afterwards.
  `CRCDF_ASSERT(a_busy_after_accept, in_valid_i && !in_stall_o |=> in_stall_o, "no parse after an accepted byte")

  // A fresh output request only comes from a parse in progress.
  `CRCDF_ASSERT(a_out_from_parse, $rose(out_valid_o) |-> $past(in_stall_o), "output request without parsing")

  // The block leaves reset with an empty output register.
  `CRCDF_ASSERT_ALWAYS(a_reset_empty, $rose(rst_ni) |-> !out_valid_o, "output valid after reset")

endmodule

bind crc16_frame_deframer crcdf_checker u_crcdf_checker (.*);

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// Testbench for crc16_frame_deframer
// Feeds received bytes into the deframer and predicts, byte by byte, which
// payload bytes must leave it. Directed tests cover the field extremes, the
// length faults, the trailer faults and frames nested inside a false header.
// A back-pressure test lets the store fill up, and a random test mixes good,
// corrupted and truncated frames with line noise. Every emitted payload byte
// is compared with the oldest predicted one.
// ----------------------------------------------------------------------------
module testbench import crcdf_pkg::*;;

  localparam int HOLD_CYCLES    = 3000;
  localparam int WATCHDOG_LIMIT = 100000;
  localparam int TAIL_CYCLES    = 40000;
  localparam int RANDOM_BYTES   = 160;
  localparam int PRINT_LIMIT    = 40;

  typedef logic [7:0] byte_list_t[$];

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } payload_beat_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] rx_byte_i   = 8'h00;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] payload_byte_o;
  logic       frame_end_o;

  // Predicted copy of the frame store.
  logic [7:0] shadow_store [STORE_DEPTH];
  logic [5:0] shadow_base = '0;
  logic [6:0] shadow_fill = '0;

  payload_beat_t payload_due_q[$];

  bit idle_enabled = 1'b1;
  bit hold_request = 1'b0;
  int error_count  = 0;
  int idle_cycles  = 0;

  crc16_frame_deframer DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .payload_byte_o (payload_byte_o),
    .frame_end_o    (frame_end_o)
  );

  always #5 clk_i = ~clk_i;

  // One bytewise step of CRC-16/XMODEM.
  function automatic logic [15:0] crc_update(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    int          k;
    c = crc ^ {b, 8'h00};
    for (k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] shadow_at(int off);
    return shadow_store[(int'(shadow_base) + off) % STORE_DEPTH];
  endfunction

  function automatic void discard_oldest(int n);
    shadow_base = 6'((int'(shadow_base) + n) % STORE_DEPTH);
    shadow_fill = 7'(int'(shadow_fill) - n);
  endfunction

  // Appends one byte to the shadow store and resolves every frame that
  // can be decided, queueing the payload bytes that the block must emit.
  function automatic void deframe_byte(logic [7:0] b);
    int          hdr;
    int          len;
    int          total;
    int          i;
    logic [15:0] crc;
    if (shadow_fill < STORE_DEPTH) begin
      shadow_store[(int'(shadow_base) + int'(shadow_fill)) % STORE_DEPTH] = b;
      shadow_fill++;
    end
    while (1) begin
      if (shadow_fill < 2) break;
      if (shadow_at(0) == START_SHORT) begin
        hdr = 2;
        len = shadow_at(1);
      end else if (shadow_at(0) == START_LONG) begin
        if (shadow_fill < 3) break;
        hdr = 3;
        len = {shadow_at(1), shadow_at(2)};
      end else begin
        discard_oldest(1);
        continue;
      end
      total = hdr + len + TRAILER_LEN;
      if (len == 0 || len > MAX_PAYLOAD || total > STORE_DEPTH) begin
        discard_oldest(1);
        continue;
      end
      if (shadow_fill < total) break;
      crc = '0;
      for (i = 0; i < len; i++) begin
        crc = crc_update(crc, shadow_at(hdr + i));
      end
      if (shadow_at(total - 1) != END_MARK ||
          crc != {shadow_at(hdr + len), shadow_at(hdr + len + 1)}) begin
        discard_oldest(1);
        continue;
      end
      for (i = 0; i < len; i++) begin
        payload_due_q.push_back('{data: shadow_at(hdr + i), last: (i == len - 1)});
      end
      discard_oldest(total);
    end
  endfunction

  function automatic byte_list_t make_frame(bit long_form, byte_list_t payload);
    byte_list_t  q;
    logic [15:0] crc;
    int          len;
    len = payload.size();
    crc = '0;
    if (long_form) begin
      q.push_back(START_LONG);
      q.push_back(8'(len >> 8));
      q.push_back(8'(len));
    end else begin
      q.push_back(START_SHORT);
      q.push_back(8'(len));
    end
    foreach (payload[i]) begin
      q.push_back(payload[i]);
      crc = crc_update(crc, payload[i]);
    end
    q.push_back(crc[15:8]);
    q.push_back(crc[7:0]);
    q.push_back(END_MARK);
    return q;
  endfunction

  function automatic byte_list_t random_payload(int len);
    byte_list_t q;
    int         i;
    for (i = 0; i < len; i++) begin
      q.push_back(8'($urandom));
    end
    return q;
  endfunction

  // Mostly short frames; now and then one close to the largest size.
  function automatic byte_list_t random_frame();
    int len;
    len = ($urandom_range(99) < 5) ? $urandom_range(40, MAX_PAYLOAD) : $urandom_range(1, 8);
    return make_frame($urandom_range(3) == 0, random_payload(len));
  endfunction

  task automatic report_mismatch(string what);
    error_count++;
    if (error_count <= PRINT_LIMIT) begin
      $display("MISMATCH at %0t: %s", $realtime, what);
    end
  endtask

  // Offers one byte and waits until the request is taken.
  task automatic send_byte(logic [7:0] b);
    if (idle_enabled && $urandom_range(99) < 8) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    deframe_byte(b);
  endtask

  task automatic send_list(byte_list_t q);
    foreach (q[i]) begin
      send_byte(q[i]);
    end
  endtask

  // Stops offering bytes until every predicted payload byte has left.
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (payload_due_q.size() != 0);
  endtask

  // Receiver side: random stalls, plus a long hold when one is requested.
  initial begin : out_stall_driver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= idle_enabled && ($urandom_range(99) < 8);
      end
    end
  end

  // Compares each emitted payload byte with the oldest prediction.
  always @(posedge clk_i) begin : result_check
    payload_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (payload_due_q.size() == 0) begin
        report_mismatch($sformatf("unexpected payload byte %02h end %0b",
                                  payload_byte_o, frame_end_o));
      end else begin
        want = payload_due_q.pop_front();
        if (payload_byte_o !== want.data) begin
          report_mismatch($sformatf("payload_byte %02h, expected %02h",
                                    payload_byte_o, want.data));
        end
        if (frame_end_o !== want.last) begin
          report_mismatch($sformatf("frame_end %0b, expected %0b on byte %02h",
                                    frame_end_o, want.last, want.data));
        end
      end
    end
  end

  // Ends the run when no request is taken on either side for too long.
  always @(posedge clk_i) begin
    if (rst_ni && ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("crc16_frame_deframer verification failed");
      $finish;
    end
  end

  // Line noise at both byte extremes, then the smallest frame in each form.
  task automatic test_field_extremes();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_list(make_frame(1'b0, '{8'hFF}));
    send_list(make_frame(1'b1, '{8'h00}));
  endtask

  // Zero and oversized lengths in both header forms.
  task automatic test_length_faults();
    send_list('{START_SHORT, 8'd0});
    send_list('{START_SHORT, 8'(MAX_PAYLOAD + 1)});
    send_list('{START_LONG, 8'd0, 8'd0});
    send_list('{START_LONG, 8'd1, 8'd0});
    send_list(make_frame(1'b0, '{8'h5A, 8'hA5}));
  endtask

  // A wrong CRC and a wrong end byte; each must be rejected, then resync.
  task automatic test_trailer_faults();
    byte_list_t q;
    q = make_frame(1'b0, '{8'h81});
    q[3] ^= 8'h01;
    send_list(q);
    q = make_frame(1'b0, '{8'h7E});
    q[5] = 8'h04;
    send_list(q);
  endtask

  // A false header whose length spans two whole frames: when its CRC fails,
  // both inner frames are released by the same byte.
  task automatic test_stacked_frames();
    send_list('{START_SHORT, 8'd15});
    send_list(make_frame(1'b0, '{8'h11, 8'h22, 8'h33, 8'h44}));
    send_list(make_frame(1'b0, '{8'h55, 8'h66, 8'h77, 8'h88}));
  endtask

  // The receiver holds off while full-size frames keep coming, so the store
  // fills and the input stalls; afterwards the sender waits for the drain.
  task automatic test_back_pressure();
    int n;
    wait_for_drain();
    hold_request = 1'b1;
    send_list(make_frame(1'b1, random_payload(MAX_PAYLOAD)));
    send_list(make_frame(1'b0, random_payload(MAX_PAYLOAD)));
    for (n = 0; n < 4; n++) begin
      send_list(make_frame(1'b0, random_payload(8)));
    end
    wait_for_drain();
  endtask

  // Mostly well-formed frames, mixed with corrupted and cut-off frames and
  // noise. The middle third runs with no idling on either side.
  task automatic test_random_traffic();
    int         sent;
    int         pick;
    byte_list_t q;
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      idle_enabled = !(sent >= RANDOM_BYTES / 3 && sent < 2 * RANDOM_BYTES / 3);
      pick = $urandom_range(99);
      q = random_frame();
      if (pick < 10) begin
        q = random_payload($urandom_range(1, 4));
      end else if (pick < 20) begin
        q[$urandom_range(q.size() - 1)] ^= 8'(1 << $urandom_range(7));
      end else if (pick < 28) begin
        q = q[0:$urandom_range(q.size() - 2)];
      end
      send_list(q);
      sent += q.size();
    end
    idle_enabled = 1'b1;
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_field_extremes();
    test_length_faults();
    test_trailer_faults();
    test_stacked_frames();
    test_back_pressure();
    test_random_traffic();
    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("crc16_frame_deframer verification clean");
    end else begin
      $display("crc16_frame_deframer verification failed");
    end
    $finish;
  end

endmodule
